### rtl/egbr_pkg.sv
// egbr_pkg: shared constants, store access types and a helper of the exp-golomb bit reader
package egbr_pkg;

  // byte store geometry
  localparam int BUFFER_DEPTH  = 4096;
  localparam int ADDR_W        = $clog2(BUFFER_DEPTH);
  localparam int MAX_READ_BITS = 32;

  // field widths
  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 12;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 16;
  localparam int CFG_W    = 13;

  // bytes gathered for one fixed-width extraction
  localparam int WINDOW_BYTES = 5;
  localparam int WINDOW_W     = WINDOW_BYTES * BYTE_W;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_UEG    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SEG    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SKIP   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_REWIND = 3'd5;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

  // leading zeros of a byte, 8 when the byte is zero
  function automatic logic [3:0] clz8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(7 - i);
    end
    return n;
  endfunction

endpackage

### rtl/egbr_channels.sv
// egbr_channels: valid/ready channel interfaces for commands and results
interface egbr_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [egbr_pkg::OPCODE_W-1:0]    opcode;
  logic [egbr_pkg::INDEX_W-1:0]     byte_index;
  logic [egbr_pkg::BYTE_W-1:0]      byte_value;
  logic [egbr_pkg::COUNT_W-1:0]     bit_count;

  modport source (output valid, opcode, byte_index, byte_value, bit_count, input ready);
  modport sink   (input valid, opcode, byte_index, byte_value, bit_count, output ready);
endinterface

interface egbr_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [egbr_pkg::VALUE_W-1:0]     result_value;
  logic                             ok;
  logic [egbr_pkg::POS_W-1:0]       bit_position;

  modport source (output valid, result_value, ok, bit_position, input ready);
  modport sink   (input valid, result_value, ok, bit_position, output ready);
endinterface

### rtl/egbr_byte_store.sv
// egbr_byte_store: byte buffer, one write and one registered read port
module egbr_byte_store (
  input  logic                        clk,
  input  egbr_pkg::store_wr_t         wr,
  input  egbr_pkg::store_rd_t         rd,
  output logic [egbr_pkg::BYTE_W-1:0] rd_data
);

  logic [egbr_pkg::BYTE_W-1:0] mem [egbr_pkg::BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### rtl/exp_golomb_bit_reader_unit.sv
// exp_golomb_bit_reader_unit: msb-first bit reader with exp-golomb decode over a byte store
//
//   channel   dir   handshake      carries
//   -------   ---   ------------   ----------------------------------------------
//   cmd       in    valid/ready    opcode, byte_index, byte_value, bit_count
//   rsp       out   valid/ready    result_value, ok, bit_position
//   cfg       in    cfg_we         cfg_wdata -> buffer_bytes
//
// one command at a time; load, skip, rewind and failed acceptance checks go straight to
// the finish state, a fixed read streams five bytes through the single store read port,
// then extracts and finishes; a code scans prefix bytes (up to 5) with a request, check and
// evaluate state per byte, then fetches the suffix window, decodes and maps the sign
// the rsp register holds a finished result while the next command is taken; a command
// that finishes while rsp is still full waits in the finish state
// synchronous reset clears position, buffer_bytes and control; store contents are kept,
// and cmd is not ready while rst is high
module exp_golomb_bit_reader_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [egbr_pkg::CFG_W-1:0] cfg_wdata,
  egbr_cmd_if.sink                   cmd,
  egbr_rsp_if.source                 rsp
);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ZREQ    = 4'd1;  // request next prefix byte
  localparam logic [3:0] S_ZCHK    = 4'd2;  // count zeros in returned byte
  localparam logic [3:0] S_ZEVAL   = 4'd3;  // end and length checks on the prefix
  localparam logic [3:0] S_FETCH   = 4'd4;  // stream window bytes
  localparam logic [3:0] S_EXTRACT = 4'd5;  // pull the bit field out of the window
  localparam logic [3:0] S_DECODE  = 4'd6;  // code number plus one
  localparam logic [3:0] S_SIGN    = 4'd7;  // unsigned or signed mapping
  localparam logic [3:0] S_FINISH  = 4'd8;  // hand result to rsp register

  localparam int POS_W = egbr_pkg::POS_W;

  logic [3:0]                       state;
  logic [egbr_pkg::CFG_W-1:0]       buffer_bytes;
  logic [POS_W-1:0]                 pos;
  logic [egbr_pkg::OPCODE_W-1:0]    op;

  // prefix scan
  logic [5:0]                       zeros;
  logic                             found;
  logic                             first;
  logic [egbr_pkg::ADDR_W-1:0]      scan_addr;

  // window fetch and extract
  logic [POS_W-1:0]                 start;
  logic [egbr_pkg::COUNT_W-1:0]     cnt;
  logic [egbr_pkg::ADDR_W-1:0]      fetch_addr;
  logic [2:0]                       issued;
  logic [2:0]                       captured;
  logic                             rd_pending;
  logic [egbr_pkg::WINDOW_W-1:0]    window;
  logic [egbr_pkg::VALUE_W-1:0]     acc;

  // pending result
  logic [egbr_pkg::VALUE_W-1:0]     res_value;
  logic                             res_ok;
  logic [POS_W-1:0]                 res_pos;

  // store access
  egbr_pkg::store_wr_t              st_wr;
  egbr_pkg::store_rd_t              st_rd;
  logic [egbr_pkg::BYTE_W-1:0]      rd_data;

  egbr_byte_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd      (st_rd),
    .rd_data (rd_data)
  );

  // end of valid data in bits, buffer_bytes clamped to the store depth
  logic [egbr_pkg::CFG_W-1:0] clamp_bytes;
  logic [POS_W-1:0]           end_bits;

  assign clamp_bytes = (buffer_bytes > egbr_pkg::CFG_W'(egbr_pkg::BUFFER_DEPTH))
                       ? egbr_pkg::CFG_W'(egbr_pkg::BUFFER_DEPTH) : buffer_bytes;
  assign end_bits    = {clamp_bytes, 3'b000};

  logic accept;
  logic out_free;

  assign cmd.ready = (state == S_IDLE) && !rst;
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  // loads go straight into the store on the accepting edge
  assign st_wr.en   = accept && (cmd.opcode == egbr_pkg::OP_LOAD);
  assign st_wr.addr = cmd.byte_index;
  assign st_wr.data = cmd.byte_value;

  assign st_rd.en   = (state == S_ZREQ) ||
                      ((state == S_FETCH) && (issued != 3'(egbr_pkg::WINDOW_BYTES)));
  assign st_rd.addr = (state == S_ZREQ) ? scan_addr : fetch_addr;

  // command checks at acceptance
  logic [POS_W:0] pos_plus_cnt;
  logic           fits;

  assign pos_plus_cnt = {1'b0, pos} + (POS_W + 1)'(cmd.bit_count);
  assign fits         = (pos_plus_cnt <= {1'b0, end_bits});

  // prefix zero count on the returned byte, bits ahead of the start masked on the first
  logic [2:0] off_eff;
  logic [7:0] masked;
  logic [3:0] lz;

  assign off_eff = first ? pos[2:0] : 3'd0;
  assign masked  = rd_data & (8'hFF >> off_eff);
  assign lz      = egbr_pkg::clz8(masked);

  // prefix checks
  logic [POS_W:0] run_end;
  logic [POS_W:0] code_end;
  logic           z_fail;

  assign run_end  = {1'b0, pos} + (POS_W + 1)'(zeros);
  assign code_end = {1'b0, pos} + (POS_W + 1)'({zeros, 1'b0}) + (POS_W + 1)'(1);
  assign z_fail   = (zeros > 6'd31) || (run_end >= {1'b0, end_bits}) ||
                    (found && (code_end > {1'b0, end_bits}));

  // field extract: align the window on the start bit, keep the top cnt bits
  logic [egbr_pkg::WINDOW_W-1:0] aligned;
  logic [egbr_pkg::VALUE_W-1:0]  field;

  assign aligned = window << start[2:0];
  assign field   = aligned[egbr_pkg::WINDOW_W-1 -: egbr_pkg::VALUE_W]
                   >> (egbr_pkg::COUNT_W'(egbr_pkg::VALUE_W) - cnt);

  // acc holds code number plus one here; magnitude is half of it
  logic [egbr_pkg::VALUE_W-1:0] mag;

  assign mag = {1'b0, acc[egbr_pkg::VALUE_W-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      buffer_bytes <= '0;
      rd_pending   <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_bytes <= cfg_wdata;
      end
      rd_pending <= st_rd.en;
      // the finish state reloads the register itself when it is taken
      if (rsp.valid && rsp.ready && (state != S_FINISH)) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op <= cmd.opcode;
            case (cmd.opcode)
              egbr_pkg::OP_LOAD: begin
                res_value <= '0;
                res_ok    <= 1'b1;
                res_pos   <= pos;
                state     <= S_FINISH;
              end
              egbr_pkg::OP_READ: begin
                if ((cmd.bit_count <= egbr_pkg::COUNT_W'(egbr_pkg::MAX_READ_BITS)) && fits) begin
                  start      <= pos;
                  cnt        <= cmd.bit_count;
                  fetch_addr <= pos[POS_W-2:3];
                  issued     <= '0;
                  captured   <= '0;
                  res_pos    <= pos_plus_cnt[POS_W-1:0];
                  state      <= S_FETCH;
                end else begin
                  res_value <= '0;
                  res_ok    <= 1'b0;
                  res_pos   <= pos;
                  state     <= S_FINISH;
                end
              end
              egbr_pkg::OP_UEG, egbr_pkg::OP_SEG: begin
                if (pos >= end_bits) begin
                  res_value <= '1;
                  res_ok    <= 1'b0;
                  res_pos   <= end_bits;
                  state     <= S_FINISH;
                end else begin
                  zeros     <= '0;
                  found     <= 1'b0;
                  first     <= 1'b1;
                  scan_addr <= pos[POS_W-2:3];
                  state     <= S_ZREQ;
                end
              end
              egbr_pkg::OP_SKIP: begin
                res_value <= '0;
                res_ok    <= fits;
                res_pos   <= fits ? pos_plus_cnt[POS_W-1:0] : pos;
                state     <= S_FINISH;
              end
              egbr_pkg::OP_REWIND: begin
                res_value <= '0;
                res_ok    <= 1'b1;
                res_pos   <= '0;
                state     <= S_FINISH;
              end
              default: begin
                res_value <= '0;
                res_ok    <= 1'b0;
                res_pos   <= pos;
                state     <= S_FINISH;
              end
            endcase
          end
        end

        S_ZREQ: begin
          state <= S_ZCHK;
        end

        S_ZCHK: begin
          zeros     <= zeros + 6'(lz) - 6'(off_eff);
          found     <= (masked != 8'd0);
          first     <= 1'b0;
          scan_addr <= scan_addr + 1'b1;
          state     <= S_ZEVAL;
        end

        S_ZEVAL: begin
          // never scan a byte at or past the end: the run check stops first
          if (z_fail) begin
            res_value <= '1;
            res_ok    <= 1'b0;
            res_pos   <= end_bits;
            state     <= S_FINISH;
          end else if (found) begin
            start      <= run_end[POS_W-1:0] + 1'b1;
            cnt        <= zeros;
            fetch_addr <= run_end[POS_W-2:3] + ((run_end[2:0] == 3'd7) ? 1'b1 : 1'b0);
            issued     <= '0;
            captured   <= '0;
            res_pos    <= code_end[POS_W-1:0];
            state      <= S_FETCH;
          end else begin
            state <= S_ZREQ;
          end
        end

        S_FETCH: begin
          if (st_rd.en) begin
            fetch_addr <= fetch_addr + 1'b1;
            issued     <= issued + 1'b1;
          end
          if (rd_pending) begin
            window   <= {window[egbr_pkg::WINDOW_W-egbr_pkg::BYTE_W-1:0], rd_data};
            captured <= captured + 1'b1;
            if (captured == 3'(egbr_pkg::WINDOW_BYTES - 1)) begin
              state <= S_EXTRACT;
            end
          end
        end

        S_EXTRACT: begin
          acc <= field;
          if (op == egbr_pkg::OP_READ) begin
            res_value <= field;
            res_ok    <= 1'b1;
            state     <= S_FINISH;
          end else begin
            state <= S_DECODE;
          end
        end

        S_DECODE: begin
          // prefix one bit above the suffix: code number plus one
          acc   <= (egbr_pkg::VALUE_W'(1) << cnt[4:0]) + acc;
          state <= S_SIGN;
        end

        S_SIGN: begin
          res_ok <= 1'b1;
          if (op == egbr_pkg::OP_UEG) begin
            res_value <= acc - 1'b1;
          end else if (acc[0]) begin
            // even code number maps to a non-positive value
            res_value <= '0 - mag;
          end else begin
            res_value <= mag;
          end
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.result_value <= res_value;
            rsp.ok           <= res_ok;
            rsp.bit_position <= res_pos;
            pos              <= res_pos;
            state            <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
